// ===== hdl/pft_pkg.sv =====
package pft_pkg;

    localparam int CNT_W      = 32;
    localparam int TIME_W     = 32;
    localparam int PPL_W      = 16;
    localparam int TICK_W     = 10;
    localparam int RATE_W     = 32;
    localparam int VOL_W      = 48;
    localparam int HOUR_W     = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int MS_PER_SEC   = 1000;
    localparam int SEC_PER_MIN  = 60;
    localparam int SEC_PER_HOUR = 3600;

    localparam logic [CFG_IDX_W-1:0] CFG_PPL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NARROW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK   = 2'd2;

    localparam logic [PPL_W-1:0]  PPL_RESET  = 16'd450;
    localparam logic [TICK_W-1:0] TICK_RESET = 10'd1;

    typedef enum logic [1:0] {
        FUNC_SAMPLE  = 2'd0,
        FUNC_RESYNC  = 2'd1,
        FUNC_CLR_VOL = 2'd2,
        FUNC_START   = 2'd3
    } t_func;

endpackage

// ===== hdl/pft_if.sv =====
interface pft_req_if;
    logic                          valid;
    logic                          ready;
    pft_pkg::t_func                func;
    logic [pft_pkg::CNT_W-1:0]     counter_value;
    logic [pft_pkg::TIME_W-1:0]    now_ticks;

    modport source (output valid, output func, output counter_value, output now_ticks,
                    input ready);
    modport sink (input valid, input func, input counter_value, input now_ticks,
                  output ready);
endinterface

interface pft_res_if;
    logic                          valid;
    logic                          ready;
    logic [pft_pkg::CNT_W-1:0]     pulse_total;
    logic [pft_pkg::RATE_W-1:0]    flow_per_second;
    logic [pft_pkg::RATE_W-1:0]    flow_per_minute;
    logic [pft_pkg::HOUR_W-1:0]    flow_per_hour;
    logic [pft_pkg::VOL_W-1:0]     volume_total;
    logic                          updated;

    modport source (output valid, output pulse_total, output flow_per_second,
                    output flow_per_minute, output flow_per_hour, output volume_total,
                    output updated, input ready);
    modport sink (input valid, input pulse_total, input flow_per_second,
                  input flow_per_minute, input flow_per_hour, input volume_total,
                  input updated, output ready);
endinterface

// ===== hdl/pulse_flow_totalizer.sv =====
// sequence: a command, or a sample that skips the divider, goes S_PREP then S_OUT, where its
// result is registered once the output is free; a flow update adds S_MUL, S_DIV, S_UPD,
// S_DIV being the bit-serial divider, one quotient bit of rate and of volume increment per cycle
// throughput: one request at a time, the next accepted once the result is in the output register
// reset: synchronous, active low; totals, snapshots and flow clear to zero, calibration
// returns to 450 pulses per liter, 32-bit counter wrap and 1 ms per tick
module pulse_flow_totalizer #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pft_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pft_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pft_req_if.sink                          i_req,
    pft_res_if.source                        o_res
);

    localparam int PROD_W = pft_pkg::CNT_W + 10;
    localparam int NUM_W  = PROD_W + FRAC_BITS;
    localparam int PP_W   = pft_pkg::PPL_W + pft_pkg::TICK_W;
    localparam int DEN_W  = PP_W + pft_pkg::TIME_W;
    localparam int QB_W   = pft_pkg::CNT_W + FRAC_BITS;
    localparam int STEP_W = $clog2(NUM_W);
    localparam int SUM_W  = ((QB_W > pft_pkg::VOL_W) ? QB_W : pft_pkg::VOL_W) + 1;
    localparam int MIN_W  = pft_pkg::RATE_W + 6;
    localparam int HR_W   = pft_pkg::RATE_W + 12;

    localparam logic [pft_pkg::VOL_W-1:0] VOL_MAX = {pft_pkg::VOL_W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_DIV,
        S_UPD,
        S_OUT
    } t_state;

    t_state                          r_state;
    logic [pft_pkg::PPL_W-1:0]       r_ppl;
    logic                            r_narrow;
    logic [pft_pkg::TICK_W-1:0]      r_tick;
    logic [pft_pkg::CNT_W-1:0]       r_prev_count;
    logic [pft_pkg::TIME_W-1:0]      r_prev_time;
    logic [pft_pkg::CNT_W-1:0]       r_pulses;
    logic [pft_pkg::RATE_W-1:0]      r_rate;
    logic [pft_pkg::VOL_W-1:0]       r_liters;

    pft_pkg::t_func                  r_func;
    logic [pft_pkg::CNT_W-1:0]       r_cnt;
    logic [pft_pkg::TIME_W-1:0]      r_now;
    logic                            r_upd;
    logic [pft_pkg::CNT_W-1:0]       r_delta;
    logic [pft_pkg::TIME_W-1:0]      r_elapsed;
    logic [PP_W-1:0]                 r_pp;
    logic [DEN_W-1:0]                r_den;
    logic [NUM_W-1:0]                r_num_a;
    logic [NUM_W-1:0]                r_num_b;
    logic [DEN_W-1:0]                r_rem_a;
    logic [pft_pkg::PPL_W-1:0]       r_rem_b;
    logic [pft_pkg::RATE_W-1:0]      r_qa;
    logic [QB_W-1:0]                 r_qb;
    logic                            r_sat;
    logic [STEP_W-1:0]               r_step;

    logic [pft_pkg::TIME_W-1:0]      w_elapsed;
    logic [pft_pkg::CNT_W-1:0]       w_delta_raw;
    logic [pft_pkg::CNT_W-1:0]       w_delta;
    logic [pft_pkg::TICK_W-1:0]      w_period;
    logic [PP_W-1:0]                 w_pp;
    logic [DEN_W-1:0]                w_den;
    logic [PROD_W-1:0]               w_prod;
    logic [DEN_W:0]                  w_sh_a;
    logic [DEN_W:0]                  w_dif_a;
    logic                            w_ge_a;
    logic [DEN_W-1:0]                n_rem_a;
    logic [pft_pkg::PPL_W:0]         w_sh_b;
    logic [pft_pkg::PPL_W:0]         w_dif_b;
    logic                            w_ge_b;
    logic [pft_pkg::PPL_W-1:0]       n_rem_b;
    logic [SUM_W-1:0]                w_vol_sum;
    logic [pft_pkg::VOL_W-1:0]       n_liters;
    logic [MIN_W-1:0]                w_min_full;
    logic [pft_pkg::RATE_W-1:0]      w_min;
    logic [HR_W-1:0]                 w_hour;

    assign i_req.ready = (r_state == S_IDLE);

    // delta and elapsed time, counter wrap at 16 or 32 bits
    assign w_elapsed   = r_now - r_prev_time;
    assign w_delta_raw = r_cnt - r_prev_count;
    assign w_delta     = r_narrow ? {16'd0, w_delta_raw[15:0]} : w_delta_raw;
    assign w_period    = (r_tick == '0) ? pft_pkg::TICK_W'(1) : r_tick;
    assign w_pp        = PP_W'(r_ppl) * PP_W'(w_period);
    assign w_den       = DEN_W'(r_pp) * DEN_W'(r_elapsed);
    assign w_prod      = PROD_W'(r_delta) * PROD_W'(pft_pkg::MS_PER_SEC);

    // restoring division, one quotient bit per cycle for rate and volume increment
    assign w_sh_a  = {r_rem_a, r_num_a[NUM_W-1]};
    assign w_dif_a = w_sh_a - {1'b0, r_den};
    assign w_ge_a  = (w_sh_a >= {1'b0, r_den});
    assign n_rem_a = w_ge_a ? w_dif_a[DEN_W-1:0] : w_sh_a[DEN_W-1:0];

    assign w_sh_b  = {r_rem_b, r_num_b[NUM_W-1]};
    assign w_dif_b = w_sh_b - {1'b0, r_ppl};
    assign w_ge_b  = (w_sh_b >= {1'b0, r_ppl});
    assign n_rem_b = w_ge_b ? w_dif_b[pft_pkg::PPL_W-1:0] : w_sh_b[pft_pkg::PPL_W-1:0];

    assign w_vol_sum = SUM_W'(r_liters) + SUM_W'(r_qb);
    assign n_liters  = (w_vol_sum > SUM_W'(VOL_MAX)) ? VOL_MAX : w_vol_sum[pft_pkg::VOL_W-1:0];

    assign w_min_full = MIN_W'(r_rate) * MIN_W'(pft_pkg::SEC_PER_MIN);
    assign w_min      = (w_min_full[MIN_W-1:pft_pkg::RATE_W] != '0) ? '1
                                                              : w_min_full[pft_pkg::RATE_W-1:0];
    assign w_hour     = HR_W'(r_rate) * HR_W'(pft_pkg::SEC_PER_HOUR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            o_res.valid  <= 1'b0;
            r_ppl        <= pft_pkg::PPL_RESET;
            r_narrow     <= 1'b0;
            r_tick       <= pft_pkg::TICK_RESET;
            r_prev_count <= '0;
            r_prev_time  <= '0;
            r_pulses     <= '0;
            r_rate       <= '0;
            r_liters     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pft_pkg::CFG_PPL:    r_ppl    <= i_cfg_data;
                    pft_pkg::CFG_NARROW: r_narrow <= i_cfg_data[0];
                    pft_pkg::CFG_TICK:   r_tick   <= i_cfg_data[pft_pkg::TICK_W-1:0];
                    default: ;
                endcase
            end

            if (o_res.valid && o_res.ready && r_state != S_OUT) begin
                o_res.valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_func  <= i_req.func;
                        r_cnt   <= i_req.counter_value;
                        r_now   <= i_req.now_ticks;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_upd   <= 1'b0;
                    r_state <= S_OUT;
                    unique case (r_func)
                        pft_pkg::FUNC_SAMPLE: begin
                            if (w_elapsed != '0) begin
                                r_prev_count <= r_cnt;
                                r_prev_time  <= r_now;
                                r_pulses     <= r_pulses + w_delta;
                                r_upd        <= 1'b1;
                                if (w_delta == '0) begin
                                    r_rate <= '0;
                                end else if (r_ppl != '0) begin
                                    r_delta   <= w_delta;
                                    r_elapsed <= w_elapsed;
                                    r_pp      <= w_pp;
                                    r_state   <= S_MUL;
                                end
                            end
                        end
                        pft_pkg::FUNC_RESYNC: begin
                            r_prev_count <= r_cnt;
                            r_pulses     <= '0;
                        end
                        pft_pkg::FUNC_CLR_VOL: begin
                            r_liters <= '0;
                        end
                        pft_pkg::FUNC_START: begin
                            r_prev_count <= r_cnt;
                        end
                    endcase
                end
                S_MUL: begin
                    r_den   <= w_den;
                    r_num_a <= NUM_W'(w_prod) << FRAC_BITS;
                    r_num_b <= NUM_W'(r_delta) << FRAC_BITS;
                    r_rem_a <= '0;
                    r_rem_b <= '0;
                    r_qa    <= '0;
                    r_qb    <= '0;
                    r_sat   <= 1'b0;
                    r_step  <= STEP_W'(NUM_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem_a <= n_rem_a;
                    r_num_a <= r_num_a << 1;
                    r_qa    <= {r_qa[pft_pkg::RATE_W-2:0], w_ge_a};
                    // any quotient bit above the rate width means saturation
                    r_sat   <= r_sat | r_qa[pft_pkg::RATE_W-1];
                    r_rem_b <= n_rem_b;
                    r_num_b <= r_num_b << 1;
                    r_qb    <= {r_qb[QB_W-2:0], w_ge_b};
                    r_step  <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_rate   <= r_sat ? '1 : r_qa;
                    r_liters <= n_liters;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (!o_res.valid || o_res.ready) begin
                        o_res.valid           <= 1'b1;
                        o_res.pulse_total     <= r_pulses;
                        o_res.flow_per_second <= r_rate;
                        o_res.flow_per_minute <= w_min;
                        o_res.flow_per_hour   <= pft_pkg::HOUR_W'(w_hour);
                        o_res.volume_total    <= r_liters;
                        o_res.updated         <= r_upd;
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_rem_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_den != '0 && r_rem_a < r_den))
        else $error("rate remainder not below divisor");

    a_rem_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_ppl != '0 && r_rem_b < r_ppl))
        else $error("volume remainder not below calibration");

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_PREP))
        else $error("accepted request not taken into prep");

    a_cmd_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP && r_func != pft_pkg::FUNC_SAMPLE) |=> !r_upd)
        else $error("command request flagged as update");

    a_minute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.flow_per_minute >= o_res.flow_per_second))
        else $error("flow per minute below flow per second");
`endif

endmodule
